/* design/pld_pkg.sv */
// Package with payload types and constants for the polyline densifier.
`default_nettype none
package pld_pkg;

  localparam int unsigned CoordW = 24;
  localparam logic [15:0] MinSpacing = 16'd64;
  localparam logic [15:0] ResetSpacing = 16'd1024;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     segment_start;
  } pld_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic                     out_segment_start;
    logic                     last_of_run;
  } pld_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat and deltas
    logic pass;      // capture the pass-through point, update previous point
    logic cnt_init;  // start the step count search at k = 1
    logic cnt_next;  // advance the step count search
    logic div_init;  // start an interpolation division for the current k
    logic div_step;  // one restoring division step on both axes
    logic emit;      // load the output register with the current point
    logic emit_last; // load the output register with the new point
    logic commit;    // new point becomes the previous point
  } pld_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;  // beat is a segment start or no previous point exists
    logic is_zero;   // zero-length step
    logic cnt_done;  // step count found
    logic div_done;  // division finished
    logic k_last;    // current k equals n
    logic out_busy;  // output register holds an untaken beat
  } pld_sts_t;

endpackage
`default_nettype wire

/* design/pld_datapath.sv */
// Datapath of the polyline densifier: step count search, dividers, output register.
`default_nettype none
module pld_datapath import pld_pkg::*; #(
  parameter int unsigned MaxSteps = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire pld_in_t     in_data_i,
  input  wire pld_cmd_t    cmd_i,
  output pld_sts_t         sts_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pld_out_t         out_data_o
);
  localparam int unsigned KW = $clog2(MaxSteps + 1);
  localparam int unsigned DW = CoordW + 1;          // delta magnitude bits
  localparam int unsigned KsW = KW + 16;            // k * spacing
  localparam int unsigned LimW = DW + KW + 16;      // saturation compare
  localparam int unsigned D2W = 2 * DW + 1;         // squared distance
  localparam int unsigned NumW = DW + KW + 1;       // 2*mag*k + n
  localparam int unsigned DCntW = $clog2(NumW + 1);

  logic [15:0] spacing_q;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q, new_x_q, new_y_q;
  logic have_prev_q;
  logic start_q;
  logic [DW-1:0] ax_q, ay_q;
  logic nx_q, ny_q;
  logic [KW-1:0] k_q, n_q;
  logic [KsW-1:0] ks_q;
  logic [D2W-1:0] d2_q;
  logic cnt_done_q;
  logic [NumW-1:0] numx_q, numy_q, remx_q, remy_q, den_q;
  logic [DCntW-1:0] dcnt_q;
  logic out_valid_q;
  pld_out_t out_q;

  // Effective spacing and the saturation test.
  logic [15:0] sp;
  logic [LimW-1:0] limit;
  logic signed [CoordW:0] dx, dy;
  assign sp = (spacing_q < MinSpacing) ? MinSpacing : spacing_q;
  assign limit = LimW'(MaxSteps) * LimW'(sp);
  assign dx = $signed({in_data_i.point_x[CoordW-1], in_data_i.point_x})
              - $signed({prev_x_q[CoordW-1], prev_x_q});
  assign dy = $signed({in_data_i.point_y[CoordW-1], in_data_i.point_y})
              - $signed({prev_y_q[CoordW-1], prev_y_q});

  // Square of k*spacing, compared against the squared distance.
  logic [2*KsW-1:0] ks2;
  logic ks_hit;
  assign ks2 = ks_q * ks_q;
  assign ks_hit = (d2_q <= D2W'(ks2));

  // Trial subtraction for the restoring dividers.
  logic [NumW-1:0] trx, try_;
  logic [NumW:0] subx, suby;
  assign trx = {remx_q[NumW-2:0], numx_q[NumW-1]};
  assign try_ = {remy_q[NumW-2:0], numy_q[NumW-1]};
  assign subx = {1'b0, trx} - {1'b0, den_q};
  assign suby = {1'b0, try_} - {1'b0, den_q};

  logic signed [CoordW-1:0] ix, iy;
  assign ix = prev_x_q + (nx_q ? -$signed(CoordW'(numx_q)) : $signed(CoordW'(numx_q)));
  assign iy = prev_y_q + (ny_q ? -$signed(CoordW'(numy_q)) : $signed(CoordW'(numy_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= ResetSpacing;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      new_x_q     <= '0;
      new_y_q     <= '0;
      start_q     <= 1'b0;
      nx_q        <= 1'b0;
      ny_q        <= 1'b0;
      ax_q        <= '0;
      ay_q        <= '0;
      d2_q        <= '0;
      k_q         <= '0;
      n_q         <= '0;
      ks_q        <= '0;
      cnt_done_q  <= 1'b0;
      numx_q      <= '0;
      numy_q      <= '0;
      remx_q      <= '0;
      remy_q      <= '0;
      den_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) spacing_q <= cfg_wdata_i;
      // Capture the beat with its deltas.
      if (cmd_i.load) begin
        new_x_q <= in_data_i.point_x;
        new_y_q <= in_data_i.point_y;
        start_q <= in_data_i.segment_start || !have_prev_q;
        nx_q <= dx[CoordW];
        ny_q <= dy[CoordW];
        ax_q <= dx[CoordW] ? DW'(-dx) : DW'(dx);
        ay_q <= dy[CoordW] ? DW'(-dy) : DW'(dy);
      end
      // Step count search: squared distance first, then one k a cycle.
      // Once the count is found, k restarts at 1 and steps with each emitted point.
      if (cmd_i.cnt_init) begin
        d2_q <= D2W'(ax_q * ax_q) + D2W'(ay_q * ay_q);
        k_q  <= KW'(1);
        ks_q <= KsW'(sp);
        cnt_done_q <= (LimW'(ax_q) > limit) || (LimW'(ay_q) > limit);
        n_q  <= KW'(MaxSteps);
      end else if (cmd_i.cnt_next) begin
        if (cnt_done_q) begin
          k_q <= KW'(1);
        end else if (ks_hit || k_q == KW'(MaxSteps)) begin
          n_q <= k_q;
          cnt_done_q <= 1'b1;
        end else begin
          k_q  <= k_q + KW'(1);
          ks_q <= ks_q + KsW'(sp);
        end
      end else if (cmd_i.emit) begin
        k_q <= k_q + KW'(1);
      end
      // Interpolation divisions: (2*mag*k + n) / (2*n), one bit a cycle.
      if (cmd_i.div_init) begin
        numx_q <= NumW'(ax_q * k_q) + NumW'(ax_q * k_q) + NumW'(n_q);
        numy_q <= NumW'(ay_q * k_q) + NumW'(ay_q * k_q) + NumW'(n_q);
        den_q  <= NumW'({n_q, 1'b0});
        remx_q <= '0;
        remy_q <= '0;
        dcnt_q <= DCntW'(NumW);
      end else if (cmd_i.div_step && dcnt_q != '0) begin
        remx_q <= subx[NumW] ? trx : subx[NumW-1:0];
        remy_q <= suby[NumW] ? try_ : suby[NumW-1:0];
        numx_q <= {numx_q[NumW-2:0], ~subx[NumW]};
        numy_q <= {numy_q[NumW-2:0], ~suby[NumW]};
        dcnt_q <= dcnt_q - DCntW'(1);
      end
      // Output register: a load wins over the departure of the previous beat.
      if (cmd_i.emit) begin
        out_q <= '{out_x: ix, out_y: iy, out_segment_start: 1'b0, last_of_run: 1'b0};
        out_valid_q <= 1'b1;
      end else if (cmd_i.emit_last || cmd_i.pass) begin
        out_q <= '{out_x: new_x_q, out_y: new_y_q,
                   out_segment_start: cmd_i.pass, last_of_run: 1'b1};
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit || cmd_i.pass) begin
        prev_x_q <= new_x_q;
        prev_y_q <= new_y_q;
        have_prev_q <= 1'b1;
      end
    end
  end

  assign sts_o.is_start = start_q;
  assign sts_o.is_zero  = (ax_q == '0) && (ay_q == '0);
  assign sts_o.cnt_done = cnt_done_q;
  assign sts_o.div_done = (dcnt_q == '0);
  assign sts_o.k_last   = (k_q >= n_q);
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

/* design/pld_ctrl.sv */
// Controller state machine of the polyline densifier.
`default_nettype none
module pld_ctrl import pld_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pld_sts_t sts_i,
  output pld_cmd_t      cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StDecide, StCount, StDivInit, StDiv, StEmit, StLast
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (sts_i.is_start) begin
          if (!sts_i.out_busy) begin
            cmd_o.pass = 1'b1;
            state_d = StIdle;
          end
        end else if (sts_i.is_zero) begin
          state_d = StIdle;
        end else begin
          cmd_o.cnt_init = 1'b1;
          state_d = StCount;
        end
      end
      StCount: begin
        cmd_o.cnt_next = 1'b1;
        if (sts_i.cnt_done) state_d = StDivInit;
      end
      StDivInit: begin
        if (sts_i.k_last) begin
          state_d = StLast;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StEmit;
      end
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = StDivInit;
        end
      end
      StLast: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_last = 1'b1;
          cmd_o.commit = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

/* design/polyline_densifier_unit.sv */
// Top level of the polyline densifier.
// Takes one route point per input beat and emits the points of a densified
// polyline. The input is stalled while a point is in work, so points are taken
// one at a time. A later point that needs n steps is taken and classified, then
// goes through the step count search (one k per cycle, n <= MaxSteps; no k is
// tried when the step count saturates on a long axis), then through one division
// per interpolated point in the two 33-step restoring dividers, one per axis,
// running side by side, and then the point itself is emitted. Output beats sit
// in one register and may be stalled; the unit waits while that register holds
// an untaken beat.
`default_nettype none
module polyline_densifier_unit import pld_pkg::*; #(
  parameter int unsigned MaxSteps = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pld_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pld_out_t         out_data_o
);
  pld_cmd_t cmd;
  pld_sts_t sts;

  pld_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  pld_datapath #(.MaxSteps(MaxSteps)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_data_i, .cmd_i(cmd), .sts_o(sts),
    .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef ASSERT_OFF
  // A stalled output beat must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed under stall");
  // Only one output load per cycle.
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.emit, cmd.emit_last, cmd.pass}))
    else $error("two output loads at once");
  // No output load while the output register is stalled.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_last || cmd.pass) |-> !(out_valid_o && out_stall_i))
    else $error("output beat overwritten");
`endif
endmodule
`default_nettype wire

/* tb/pld_checker.sv */
// Checker for the polyline densifier: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module pld_checker import pld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  pld_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  pld_out_t    out_data,
  output int          fail_count,
  output int          pending_count
);

  localparam int unsigned StepLimit = 64;
  localparam int ExpDepth = 1024;

  logic [15:0]        spacing_reg;
  logic signed [47:0] last_x;
  logic signed [47:0] last_y;
  logic               have_last;
  pld_out_t           exp_mem [ExpDepth];
  int                 exp_wr;
  int                 exp_rd;

  assign pending_count = exp_wr - exp_rd;

  // Append one expected beat at the tail of the ring.
  task automatic expect_beat(pld_out_t o);
    exp_mem[exp_wr % ExpDepth] = o;
    exp_wr = exp_wr + 1;
  endtask

  // Rounded offset delta * k / n, ties away from zero.
  function automatic logic signed [47:0] lerp_offset(logic signed [47:0] delta, int k, int n);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (delta < 0) ? -delta : delta;
    q = (2 * mag * k + n) / (2 * n);
    return (delta < 0) ? -$signed(q[47:0]) : $signed(q[47:0]);
  endfunction

  // Smallest k with (k * spacing)^2 >= d^2, saturated.
  function automatic int gap_steps(logic signed [47:0] dx, logic signed [47:0] dy);
    logic [63:0] s;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] d2;
    logic [63:0] ks;
    s = (spacing_reg < MinSpacing) ? 64'(MinSpacing) : 64'(spacing_reg);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > StepLimit * s || ay > StepLimit * s) return StepLimit;
    d2 = ax * ax + ay * ay;
    for (int k = 1; k < StepLimit; k++) begin
      ks = k * s;
      if (ks * ks >= d2) return k;
    end
    return StepLimit;
  endfunction

  // Expected beats for one accepted route point.
  task automatic densify_point(pld_in_t p);
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] dx;
    logic signed [47:0] dy;
    pld_out_t o;
    int n;
    x = p.point_x;
    y = p.point_y;
    if (p.segment_start || !have_last) begin
      o = '{out_x: p.point_x, out_y: p.point_y, out_segment_start: 1'b1, last_of_run: 1'b1};
      expect_beat(o);
      last_x = x;
      last_y = y;
      have_last = 1'b1;
    end else if (x != last_x || y != last_y) begin
      dx = x - last_x;
      dy = y - last_y;
      n = gap_steps(dx, dy);
      for (int k = 1; k < n; k++) begin
        o.out_x = 24'(last_x + lerp_offset(dx, k, n));
        o.out_y = 24'(last_y + lerp_offset(dy, k, n));
        o.out_segment_start = 1'b0;
        o.last_of_run = 1'b0;
        expect_beat(o);
      end
      o = '{out_x: p.point_x, out_y: p.point_y, out_segment_start: 1'b0, last_of_run: 1'b1};
      expect_beat(o);
      last_x = x;
      last_y = y;
    end
  endtask

  // Track the register, predict on input beats, compare on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    pld_out_t e;
    if (!rst_ni) begin
      spacing_reg <= ResetSpacing;
      last_x = '0;
      last_y = '0;
      have_last = 1'b0;
      exp_wr = 0;
      exp_rd = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) spacing_reg <= cfg_wdata;
      if (in_valid && !in_stall) densify_point(in_data);
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          $error("unexpected output beat x=%0d y=%0d", out_data.out_x, out_data.out_y);
          fail_count <= fail_count + 1;
        end else begin
          e = exp_mem[exp_rd % ExpDepth];
          exp_rd = exp_rd + 1;
          if (e.out_x !== out_data.out_x)
            $error("out_x expected %0d actual %0d", e.out_x, out_data.out_x);
          if (e.out_y !== out_data.out_y)
            $error("out_y expected %0d actual %0d", e.out_y, out_data.out_y);
          if (e.out_segment_start !== out_data.out_segment_start)
            $error("out_segment_start expected %0b actual %0b",
                   e.out_segment_start, out_data.out_segment_start);
          if (e.last_of_run !== out_data.last_of_run)
            $error("last_of_run expected %0b actual %0b", e.last_of_run, out_data.last_of_run);
          if (e !== out_data) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the polyline densifier: stimulus, register writes and verdict.
`timescale 1ns / 100ps
module tb_top import pld_pkg::*; ();

  localparam int CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pld_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pld_out_t    out_data;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          stall_left = 0;
  logic signed [23:0] cur_x = '0;
  logic signed [23:0] cur_y = '0;

  always #10 clk_i = ~clk_i;

  polyline_densifier_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  pld_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls for a random length before taking each beat.
  always @(posedge clk_i) begin
    int w;
    if (out_valid && !out_stall) begin
      w = $urandom_range(0, 5);
      stall_left <= w;
      out_stall <= (w != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // Send one route point, with a random gap first.
  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, logic seg);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{point_x: x, point_y: y, segment_start: seg};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Wait for all expected beats, then let a zero-length step finish.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_spacing(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // A well-formed run: a start point, then steps of bounded size.
  task automatic random_run(int len, int reach);
    cur_x = 24'($urandom);
    cur_y = 24'($urandom);
    send_point(cur_x, cur_y, 1'b1);
    for (int i = 0; i < len; i++) begin
      cur_x = cur_x + 24'($urandom_range(0, 2 * reach)) - 24'(reach);
      cur_y = cur_y + 24'($urandom_range(0, 2 * reach)) - 24'(reach);
      if ($urandom_range(0, 9) == 0) send_point(cur_x, cur_y, 1'b0);
      send_point(cur_x, cur_y, 1'b0);
    end
  endtask

  initial begin
    logic [15:0] spacings[5];
    spacings = '{16'd64, 16'd0, 16'd300, 16'd65535, 16'd1024};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first point without flag, zero step, extremes, saturation.
    send_point(24'sd100, -24'sd50, 1'b0);
    send_point(24'sd100, -24'sd50, 1'b0);
    send_point(24'sd2000, 24'sd1500, 1'b0);
    send_point(24'sd2000, 24'sd1500, 1'b0);
    send_point(24'sd2001, 24'sd1500, 1'b0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    send_point(-24'sh800000, -24'sh800000, 1'b0);
    send_point(24'sh7FFFFF, -24'sh800000, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b1);
    send_point(-24'sd3, 24'sd5, 1'b0);
    write_spacing(16'd0);
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd65, -24'sd7, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b1);
    write_spacing(16'd65535);
    send_point(24'sh7FFFFF, 24'sd0, 1'b0);
    send_point(-24'sh800000, 24'sh7FFFFF, 1'b0);
    send_point(24'sd1, 24'sd1, 1'b0);

    // Random phases across spacing settings; mostly short steps.
    for (int ph = 0; ph < 5; ph++) begin
      write_spacing(spacings[ph]);
      for (int r = 0; r < 6; r++) begin
        case ($urandom_range(0, 3))
          0: random_run(10, 4 * 64);
          1: random_run(10, 3000);
          2: random_run(10, 30);
          default: begin
            send_point(24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
            send_point(24'($urandom), 24'($urandom), 1'b0);
          end
        endcase
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
